@@ sv/assert_macros.svh @@
// Assertion macros for the checker file of the packet ring.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define ASSERT_ON(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error("%m: assertion failed");

// Condition must never be seen at a rising clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
	`ASSERT_ON(label, clk, rst_n, !(cond))

`endif

@@ sv/pktring_pkg.sv @@
// Package for the packet ring: field widths, command and result codes,
// and the control and status structs between controller and datapath. No dependencies.
package pktring_pkg;

	localparam int ADDR_W = 32;
	localparam int PLEN_W = 12;
	localparam int WANT_W = 16;
	localparam int ID_W   = 16;
	localparam int KIND_W = 2;
	localparam int SLOT_W = ADDR_W + PLEN_W;

	localparam logic CMD_ARRIVE = 1'b0;
	localparam logic CMD_READ   = 1'b1;

	localparam logic [KIND_W-1:0] KIND_STORED  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_SERVED  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_BLOCKED = 2'd2;
	localparam logic [KIND_W-1:0] KIND_WOKEN   = 2'd3;

	typedef struct packed {
		logic load;
		logic push;
		logic fetch;
		logic take;
		logic block;
		logic emit_stored;
	} ctrl_cmd_t;

	typedef struct packed {
		logic is_read;
		logic empty;
		logic job_pending;
	} dp_status_t;

endpackage

@@ sv/packet_ring_with_pending_read.sv @@
// Top level of the packet ring with one pending read.
// Depends on pktring_pkg, pktring_ctrl, pktring_dp and pktring_ram.
//
// Channel   Handshake               Ports
// command   start & !busy           cmd, pkt_addr, pkt_len, dest_addr, want_len, requester
// result    done, one-cycle strobe  kind, src_addr, copy_dest, copy_len, reader_id, overwrote
//
// An arrival with no pending job or a blocked read ends in DECODE; a served read goes on to TAKE,
// and an arrival that wakes the pending reader goes on through FETCH and then TAKE.
// The slot RAM's registered read port sets the extra states: TAKE waits for the head slot read,
// and FETCH comes first when the arrival writes the same RAM in DECODE, before the read.
// The result strobe comes in the same cycle that busy falls.
// Reset is asynchronous and clears the ring pointers and the pending job; slots stay unwritten.
// The result side cannot stall, and busy is the only back pressure on the command side.
module packet_ring_with_pending_read import pktring_pkg::*; #(
	parameter int RING_DEPTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic              cmd,
	input  logic [ADDR_W-1:0] pkt_addr,
	input  logic [PLEN_W-1:0] pkt_len,
	input  logic [ADDR_W-1:0] dest_addr,
	input  logic [WANT_W-1:0] want_len,
	input  logic [ID_W-1:0]   requester,
	output logic              done,
	output logic [KIND_W-1:0] kind,
	output logic [ADDR_W-1:0] src_addr,
	output logic [ADDR_W-1:0] copy_dest,
	output logic [PLEN_W-1:0] copy_len,
	output logic [ID_W-1:0]   reader_id,
	output logic              overwrote
);

	ctrl_cmd_t  ctrl_cmd;
	dp_status_t dp_status;

	pktring_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.status(dp_status),
		.cmd   (ctrl_cmd),
		.busy  (busy)
	);

	pktring_dp #(
		.RING_DEPTH(RING_DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (ctrl_cmd),
		.status   (dp_status),
		.in_cmd   (cmd),
		.pkt_addr (pkt_addr),
		.pkt_len  (pkt_len),
		.dest_addr(dest_addr),
		.want_len (want_len),
		.requester(requester),
		.done     (done),
		.kind     (kind),
		.src_addr (src_addr),
		.copy_dest(copy_dest),
		.copy_len (copy_len),
		.reader_id(reader_id),
		.overwrote(overwrote)
	);

endmodule

@@ sv/pktring_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module pktring_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic                             re,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ sv/pktring_ctrl.sv @@
// Controller state machine of the packet ring.
// Depends on pktring_pkg for the command and status structs.
module pktring_ctrl import pktring_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  dp_status_t status,
	output ctrl_cmd_t  cmd,
	output logic       busy
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_DECODE = 4'b0010,
		ST_FETCH  = 4'b0100,
		ST_TAKE   = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (status.is_read == CMD_ARRIVE) begin
					cmd.push = 1'b1;
					if (status.job_pending) begin
						state_d = ST_FETCH;
					end else begin
						cmd.emit_stored = 1'b1;
						state_d         = ST_IDLE;
					end
				end else if (status.empty) begin
					cmd.block = 1'b1;
					state_d   = ST_IDLE;
				end else begin
					cmd.fetch = 1'b1;
					state_d   = ST_TAKE;
				end
			end
			ST_FETCH: begin
				cmd.fetch = 1'b1;
				state_d   = ST_TAKE;
			end
			ST_TAKE: begin
				cmd.take = 1'b1;
				state_d  = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);

endmodule

@@ sv/pktring_dp.sv @@
// Datapath of the packet ring: transaction registers, ring pointers, pending job and result registers.
// Depends on pktring_pkg and pktring_ram.
module pktring_dp import pktring_pkg::*; #(
	parameter int RING_DEPTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ctrl_cmd_t         cmd,
	output dp_status_t        status,
	input  logic              in_cmd,
	input  logic [ADDR_W-1:0] pkt_addr,
	input  logic [PLEN_W-1:0] pkt_len,
	input  logic [ADDR_W-1:0] dest_addr,
	input  logic [WANT_W-1:0] want_len,
	input  logic [ID_W-1:0]   requester,
	output logic              done,
	output logic [KIND_W-1:0] kind,
	output logic [ADDR_W-1:0] src_addr,
	output logic [ADDR_W-1:0] copy_dest,
	output logic [PLEN_W-1:0] copy_len,
	output logic [ID_W-1:0]   reader_id,
	output logic              overwrote
);

	localparam int IW = $clog2(RING_DEPTH > 1 ? RING_DEPTH : 2);
	localparam logic [IW-1:0] LAST = IW'(RING_DEPTH - 1);

	function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] i);
		return (i == LAST) ? '0 : i + IW'(1);
	endfunction

	logic              cmd_q;
	logic [ADDR_W-1:0] pkt_addr_q;
	logic [PLEN_W-1:0] pkt_len_q;
	logic [ADDR_W-1:0] dest_q;
	logic [WANT_W-1:0] want_q;
	logic [ID_W-1:0]   req_q;

	logic [IW-1:0]     head_q;
	logic [IW-1:0]     tail_q;
	logic              ovw_q;
	logic              job_pending_q;
	logic [ADDR_W-1:0] job_dest_q;
	logic [WANT_W-1:0] job_size_q;
	logic [ID_W-1:0]   job_thread_q;

	logic              done_q;
	logic [KIND_W-1:0] kind_q;
	logic [ADDR_W-1:0] src_q;
	logic [ADDR_W-1:0] cdest_q;
	logic [PLEN_W-1:0] clen_q;
	logic [ID_W-1:0]   rid_q;
	logic              ovw_out_q;

	logic [IW-1:0]     tail_nx;
	logic [IW-1:0]     head_nx;
	logic              wrap;
	logic [SLOT_W-1:0] rdata;
	logic [ADDR_W-1:0] slot_addr_r;
	logic [PLEN_W-1:0] slot_len_r;
	logic [WANT_W-1:0] want_sel;
	logic              take_all;
	logic [PLEN_W-1:0] take_n;
	logic              ram_we;
	logic [IW-1:0]     ram_waddr;
	logic [SLOT_W-1:0] ram_wdata;

	assign tail_nx     = ring_next(tail_q);
	assign head_nx     = ring_next(head_q);
	assign wrap        = (tail_nx == head_q);
	assign slot_addr_r = rdata[SLOT_W-1:PLEN_W];
	assign slot_len_r  = rdata[PLEN_W-1:0];
	assign want_sel    = (cmd_q == CMD_READ) ? want_q : job_size_q;
	assign take_all    = (want_sel >= WANT_W'(slot_len_r));
	assign take_n      = take_all ? slot_len_r : want_sel[PLEN_W-1:0];

	assign ram_we    = cmd.push | (cmd.take & ~take_all);
	assign ram_waddr = cmd.push ? tail_q : head_q;
	assign ram_wdata = cmd.push ? {pkt_addr_q, pkt_len_q}
		: {slot_addr_r + ADDR_W'(take_n), slot_len_r - take_n};

	pktring_ram #(
		.WIDTH(SLOT_W),
		.DEPTH(RING_DEPTH)
	) u_slots (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (cmd.fetch),
		.raddr(head_q),
		.rdata(rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q      <= in_cmd;
			pkt_addr_q <= pkt_addr;
			pkt_len_q  <= pkt_len;
			dest_q     <= dest_addr;
			want_q     <= want_len;
			req_q      <= requester;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q        <= '0;
			tail_q        <= '0;
			ovw_q         <= 1'b0;
			job_pending_q <= 1'b0;
			job_dest_q    <= '0;
			job_size_q    <= '0;
			job_thread_q  <= '0;
		end else begin
			if (cmd.push) begin
				tail_q <= tail_nx;
				ovw_q  <= wrap;
				if (wrap) begin
					head_q <= head_nx;
				end
			end else if (cmd.take) begin
				if (take_all) begin
					head_q <= head_nx;
				end
				if (cmd_q == CMD_ARRIVE) begin
					job_pending_q <= 1'b0;
				end
			end
			if (cmd.block) begin
				job_pending_q <= 1'b1;
				job_dest_q    <= dest_q;
				job_size_q    <= want_q;
				job_thread_q  <= req_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.emit_stored | cmd.block | cmd.take;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_stored) begin
			kind_q    <= KIND_STORED;
			src_q     <= '0;
			cdest_q   <= '0;
			clen_q    <= '0;
			rid_q     <= '0;
			ovw_out_q <= wrap;
		end else if (cmd.block) begin
			kind_q    <= KIND_BLOCKED;
			src_q     <= '0;
			cdest_q   <= dest_q;
			clen_q    <= '0;
			rid_q     <= req_q;
			ovw_out_q <= 1'b0;
		end else if (cmd.take) begin
			src_q  <= slot_addr_r;
			clen_q <= take_n;
			if (cmd_q == CMD_READ) begin
				kind_q    <= KIND_SERVED;
				cdest_q   <= dest_q;
				rid_q     <= req_q;
				ovw_out_q <= 1'b0;
			end else begin
				kind_q    <= KIND_WOKEN;
				cdest_q   <= job_dest_q;
				rid_q     <= job_thread_q;
				ovw_out_q <= ovw_q;
			end
		end
	end

	assign status.is_read     = cmd_q;
	assign status.empty       = (head_q == tail_q);
	assign status.job_pending = job_pending_q;

	assign done      = done_q;
	assign kind      = kind_q;
	assign src_addr  = src_q;
	assign copy_dest = cdest_q;
	assign copy_len  = clen_q;
	assign reader_id = rid_q;
	assign overwrote = ovw_out_q;

endmodule

@@ sv/pktring_checker.sv @@
// Port-level checker for the packet ring, attached to the top level by a bind statement.
// Depends on pktring_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pktring_checker import pktring_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input logic [KIND_W-1:0] kind,
	input logic [ADDR_W-1:0] src_addr,
	input logic [PLEN_W-1:0] copy_len,
	input logic              overwrote
);

	logic copy_free;

	assign copy_free = (kind == KIND_STORED) || (kind == KIND_BLOCKED);

	`ASSERT_ON(a_accept_busy, clk, arst_n, start && !busy |=> busy)
	`ASSERT_NEVER(a_done_while_busy, clk, arst_n, done && busy)
	`ASSERT_ON(a_rise_no_done, clk, arst_n, $rose(busy) |-> !done)
	`ASSERT_ON(a_no_copy, clk, arst_n, done && copy_free |-> src_addr == '0 && copy_len == '0)
	`ASSERT_ON(a_ovw_arrival, clk, arst_n, done && (kind == KIND_SERVED || kind == KIND_BLOCKED) |-> !overwrote)

endmodule

bind packet_ring_with_pending_read pktring_checker u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.done     (done),
	.kind     (kind),
	.src_addr (src_addr),
	.copy_len (copy_len),
	.overwrote(overwrote)
);

@@ sim/tb_packet_ring_with_pending_read.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for packet_ring_with_pending_read: a queue-fed command driver,
// a result monitor and a cycle-free predictor of the descriptor ring and its pending read.
// Depends on pktring_pkg and the packet_ring_with_pending_read RTL.
module tb_packet_ring_with_pending_read;
	import pktring_pkg::*;

	localparam int RING_DEPTH   = 16;
	localparam int N_PHASES     = 20;
	localparam int PHASE_ITEMS  = 100;
	localparam int QUIET_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 10;

	typedef struct {
		logic              cmd;
		logic [ADDR_W-1:0] pkt_addr;
		logic [PLEN_W-1:0] pkt_len;
		logic [ADDR_W-1:0] dest_addr;
		logic [WANT_W-1:0] want_len;
		logic [ID_W-1:0]   requester;
		int unsigned       gap;
	} ring_cmd_t;

	typedef struct {
		logic [KIND_W-1:0] kind;
		logic [ADDR_W-1:0] src_addr;
		logic [ADDR_W-1:0] copy_dest;
		logic [PLEN_W-1:0] copy_len;
		logic [ID_W-1:0]   reader_id;
		logic              overwrote;
	} copy_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	logic              cmd = CMD_ARRIVE;
	logic [ADDR_W-1:0] pkt_addr = '0;
	logic [PLEN_W-1:0] pkt_len = '0;
	logic [ADDR_W-1:0] dest_addr = '0;
	logic [WANT_W-1:0] want_len = '0;
	logic [ID_W-1:0]   requester = '0;
	logic              done;
	logic [KIND_W-1:0] kind;
	logic [ADDR_W-1:0] src_addr;
	logic [ADDR_W-1:0] copy_dest;
	logic [PLEN_W-1:0] copy_len;
	logic [ID_W-1:0]   reader_id;
	logic              overwrote;

	ring_cmd_t    pending_cmds[$];
	copy_result_t expected_copies[$];
	ring_cmd_t    drv_cmd;
	logic         txn_taken = 1'b0;
	int unsigned  idle_left = 0;
	int unsigned  quiet_cycles = 0;
	int           total_cmds = 0;
	int           taken_count = 0;
	int           fail_count = 0;

	logic [ADDR_W-1:0] ring_addr[RING_DEPTH];
	logic [PLEN_W-1:0] ring_len[RING_DEPTH];
	int unsigned       ring_head;
	int unsigned       ring_tail;
	logic              job_waiting;
	logic [ADDR_W-1:0] job_dest;
	logic [WANT_W-1:0] job_size;
	logic [ID_W-1:0]   job_thread;

	packet_ring_with_pending_read #(
		.RING_DEPTH(RING_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.pkt_addr(pkt_addr),
		.pkt_len(pkt_len),
		.dest_addr(dest_addr),
		.want_len(want_len),
		.requester(requester),
		.done(done),
		.kind(kind),
		.src_addr(src_addr),
		.copy_dest(copy_dest),
		.copy_len(copy_len),
		.reader_id(reader_id),
		.overwrote(overwrote)
	);

	always #6 clk = ~clk;

	function automatic int unsigned pick_gap(input bit no_idle);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 60);
	endfunction

	task automatic add_cmd(input logic c, input logic [ADDR_W-1:0] pa,
			input logic [PLEN_W-1:0] pl, input logic [ADDR_W-1:0] da,
			input logic [WANT_W-1:0] wl, input logic [ID_W-1:0] rq, input bit no_idle);
		ring_cmd_t item;
		item.cmd = c;
		item.pkt_addr = pa;
		item.pkt_len = pl;
		item.dest_addr = da;
		item.want_len = wl;
		item.requester = rq;
		item.gap = pick_gap(no_idle);
		pending_cmds.push_back(item);
		total_cmds++;
	endtask

	function automatic logic [PLEN_W-1:0] rand_pkt_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 5)
			return '0;
		else if (r < 10)
			return '1;
		else if (r < 55)
			return PLEN_W'($urandom_range(1, 256));
		else
			return PLEN_W'($urandom);
	endfunction

	function automatic logic [WANT_W-1:0] rand_want();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 5)
			return '0;
		else if (r < 40)
			return WANT_W'($urandom_range(1, 64));
		else if (r < 70)
			return WANT_W'($urandom_range(0, 4095));
		else
			return WANT_W'($urandom);
	endfunction

	task automatic clear_ring_model();
		for (int i = 0; i < RING_DEPTH; i++) begin
			ring_addr[i] = '0;
			ring_len[i] = '0;
		end
		ring_head = 0;
		ring_tail = 0;
		job_waiting = 1'b0;
		job_dest = '0;
		job_size = '0;
		job_thread = '0;
	endtask

	task automatic take_head(input logic [WANT_W-1:0] want, output logic [ADDR_W-1:0] src,
			output logic [PLEN_W-1:0] n);
		logic [PLEN_W-1:0] len;
		len = ring_len[ring_head];
		n = (want < len) ? want[PLEN_W-1:0] : len;
		src = ring_addr[ring_head];
		if (n == len) begin
			ring_head = (ring_head + 1) % RING_DEPTH;
		end else begin
			ring_addr[ring_head] = ring_addr[ring_head] + n;
			ring_len[ring_head] = len - n;
		end
	endtask

	task automatic predict_copy();
		copy_result_t      r;
		logic [ADDR_W-1:0] src;
		logic [PLEN_W-1:0] n;
		r.kind = KIND_STORED;
		r.src_addr = '0;
		r.copy_dest = '0;
		r.copy_len = '0;
		r.reader_id = '0;
		r.overwrote = 1'b0;
		if (cmd == CMD_ARRIVE) begin
			ring_addr[ring_tail] = pkt_addr;
			ring_len[ring_tail] = pkt_len;
			ring_tail = (ring_tail + 1) % RING_DEPTH;
			if (ring_tail == ring_head) begin
				ring_head = (ring_head + 1) % RING_DEPTH;
				r.overwrote = 1'b1;
			end
			if (job_waiting) begin
				take_head(job_size, src, n);
				r.kind = KIND_WOKEN;
				r.src_addr = src;
				r.copy_len = n;
				r.copy_dest = job_dest;
				r.reader_id = job_thread;
				job_waiting = 1'b0;
			end
		end else if (ring_head != ring_tail) begin
			take_head(want_len, src, n);
			r.kind = KIND_SERVED;
			r.src_addr = src;
			r.copy_len = n;
			r.copy_dest = dest_addr;
			r.reader_id = requester;
		end else begin
			r.kind = KIND_BLOCKED;
			job_waiting = 1'b1;
			job_dest = dest_addr;
			job_size = want_len;
			job_thread = requester;
			r.copy_dest = dest_addr;
			r.reader_id = requester;
		end
		expected_copies.push_back(r);
	endtask

	task automatic check_copy();
		copy_result_t e;
		if (expected_copies.size() == 0) begin
			fail_count++;
			if (fail_count <= 10)
				$display("unexpected result: kind %0d src %h dest %h len %0d id %h ovw %b",
					kind, src_addr, copy_dest, copy_len, reader_id, overwrote);
		end else begin
			e = expected_copies.pop_front();
			if (kind !== e.kind || src_addr !== e.src_addr || copy_dest !== e.copy_dest ||
					copy_len !== e.copy_len || reader_id !== e.reader_id ||
					overwrote !== e.overwrote) begin
				fail_count++;
				if (fail_count <= 10) begin
					$display("mismatch exp: kind %0d src %h dest %h len %0d id %h ovw %b",
						e.kind, e.src_addr, e.copy_dest, e.copy_len, e.reader_id,
						e.overwrote);
					$display("mismatch got: kind %0d src %h dest %h len %0d id %h ovw %b",
						kind, src_addr, copy_dest, copy_len, reader_id, overwrote);
				end
			end
		end
	endtask

	always @(negedge clk) begin
		if (arst_n && !(start && !txn_taken)) begin
			if (idle_left > 0) begin
				start <= 1'b0;
				idle_left <= idle_left - 1;
			end else if (pending_cmds.size() > 0) begin
				drv_cmd = pending_cmds.pop_front();
				cmd <= drv_cmd.cmd;
				pkt_addr <= drv_cmd.pkt_addr;
				pkt_len <= drv_cmd.pkt_len;
				dest_addr <= drv_cmd.dest_addr;
				want_len <= drv_cmd.want_len;
				requester <= drv_cmd.requester;
				start <= 1'b1;
				idle_left <= (pending_cmds.size() > 0) ? pending_cmds[0].gap : 0;
			end else begin
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			txn_taken <= 1'b0;
			quiet_cycles <= 0;
			clear_ring_model();
		end else begin
			txn_taken <= start && !busy;
			if (done)
				check_copy();
			if (start && !busy) begin
				predict_copy();
				taken_count++;
			end
			if (done || (start && !busy)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		int  arrive_pct;
		bit  no_idle;
		add_cmd(CMD_READ, $urandom, PLEN_W'($urandom), '1, '1, '1, 1'b0);
		add_cmd(CMD_READ, $urandom, PLEN_W'($urandom), '0, 16'd5, '0, 1'b0);
		add_cmd(CMD_ARRIVE, 32'hFFFF_FFFE, '1, $urandom, WANT_W'($urandom),
			ID_W'($urandom), 1'b0);
		add_cmd(CMD_READ, $urandom, PLEN_W'($urandom), $urandom, '0, ID_W'($urandom), 1'b0);
		add_cmd(CMD_READ, $urandom, PLEN_W'($urandom), $urandom, '1, ID_W'($urandom), 1'b0);
		add_cmd(CMD_ARRIVE, '0, '0, $urandom, WANT_W'($urandom), ID_W'($urandom), 1'b0);
		add_cmd(CMD_READ, $urandom, PLEN_W'($urandom), $urandom, '0, ID_W'($urandom), 1'b0);
		add_cmd(CMD_READ, $urandom, PLEN_W'($urandom), $urandom, '0, ID_W'($urandom), 1'b0);
		add_cmd(CMD_ARRIVE, '1, '0, $urandom, WANT_W'($urandom), ID_W'($urandom), 1'b0);
		add_cmd(CMD_ARRIVE, 32'h0000_1000, 12'd100, $urandom, WANT_W'($urandom),
			ID_W'($urandom), 1'b0);
		add_cmd(CMD_READ, $urandom, PLEN_W'($urandom), $urandom, 16'd100, ID_W'($urandom),
			1'b0);
		for (int i = 0; i < RING_DEPTH; i++)
			add_cmd(CMD_ARRIVE, $urandom, (i == RING_DEPTH - 1) ? '1 : rand_pkt_len(),
				$urandom, WANT_W'($urandom), ID_W'($urandom), 1'b1);

		for (int p = 0; p < N_PHASES; p++) begin
			case (p % 4)
				0: arrive_pct = 90;
				1: arrive_pct = 10;
				default: arrive_pct = $urandom_range(25, 75);
			endcase
			no_idle = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < PHASE_ITEMS; i++)
				add_cmd(($urandom_range(0, 99) < arrive_pct) ? CMD_ARRIVE : CMD_READ,
					$urandom, rand_pkt_len(), $urandom, rand_want(), ID_W'($urandom),
					no_idle);
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		wait (taken_count == total_cmds && expected_copies.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && expected_copies.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+sv
sv/pktring_pkg.sv
sv/pktring_ram.sv
sv/pktring_ctrl.sv
sv/pktring_dp.sv
sv/packet_ring_with_pending_read.sv
sv/pktring_checker.sv
sim/tb_packet_ring_with_pending_read.sv
